[design/wsrm_pkg.sv]
// Shared types, character codes and register indexes for the wildcard star matcher.
// Depends on nothing; every other file of the block imports it.
package wsrm_pkg;

    localparam int PAT_BYTES  = 16;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 5;

    typedef logic [7:0] t_byte;
    typedef t_byte [PAT_BYTES-1:0] t_pattern;

    localparam t_byte STAR_CH = 8'h2A;
    localparam t_byte DOT_CH  = 8'h2E;

    // Register index, taken from paddr[4:3] (registers are 8 bytes apart).
    typedef enum logic [1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_idx;

    // A pattern byte accepts a text byte when it is a dot or equal to it.
    function automatic logic accepts(input t_byte pat, input t_byte ch);
        accepts = (pat == DOT_CH) || (pat == ch);
    endfunction

endpackage

[design/wsrm_ifs.sv]
// Valid/ready stream interfaces for the input words and result words of the matcher.
// Depends on wsrm_pkg for the byte type.
interface wsrm_in_if;
    logic              valid;
    logic              ready;
    wsrm_pkg::t_byte   text_char;
    logic              last_char;
    logic              empty_text;

    modport source (output valid, output text_char, output last_char, output empty_text,
                    input ready);
    modport sink   (input valid, input text_char, input last_char, input empty_text,
                    output ready);
endinterface

interface wsrm_out_if;
    logic valid;
    logic ready;
    logic prefix_matches;
    logic text_done;

    modport source (output valid, output prefix_matches, output text_done, input ready);
    modport sink   (input valid, input prefix_matches, input text_done, output ready);
endinterface

[design/wsrm_row_logic.sv]
// Combinational next-row and empty-text-row logic for the match row.
// Depends on wsrm_pkg for the pattern type, the star code and accepts().
module wsrm_row_logic #(
    parameter int MAX_PATTERN = 16
) (
    input  wsrm_pkg::t_pattern   i_pattern,
    input  wsrm_pkg::t_byte      i_char,
    input  logic [MAX_PATTERN:0] i_row,
    output logic [MAX_PATTERN:0] o_step_row,
    output logic [MAX_PATTERN:0] o_empty_row
);
    import wsrm_pkg::*;

    // Bit j means the text so far matches the first j pattern bytes. A star
    // at byte j-1 folds in bit j-2 of the new row, so stars chain two
    // positions at a time across the row.
    always_comb begin
        o_step_row     = '0;
        o_empty_row    = '0;
        o_empty_row[0] = 1'b1;
        // A leading star matches nothing.
        if (i_pattern[0] != STAR_CH) begin
            o_step_row[1] = i_row[0] & accepts(i_pattern[0], i_char);
        end
        for (int j = 2; j <= MAX_PATTERN; j++) begin
            if (i_pattern[j-1] == STAR_CH) begin
                o_step_row[j]  = o_step_row[j-2] |
                                 (i_row[j] & accepts(i_pattern[j-2], i_char));
                o_empty_row[j] = o_empty_row[j-2];
            end else begin
                o_step_row[j]  = i_row[j-1] & accepts(i_pattern[j-1], i_char);
            end
        end
    end

endmodule

[design/wildcard_star_regex_matcher.sv]
// Top level of the streaming wildcard star matcher: APB pattern registers, word pipeline.
// Depends on wsrm_pkg, wsrm_in_if, wsrm_out_if and wsrm_row_logic.
//
// The matcher checks streamed text, one byte per input word, against a
// pattern of up to MAX_PATTERN bytes in which a dot matches any byte and a
// byte followed by a star matches zero or more of that byte. Each word gives
// exactly one result word: prefix_matches says whether the text seen so far
// matches the whole pattern, and text_done marks the result of the final word
// of a text. A word with empty_text set carries no byte; it ends the text
// with the answer for the bytes seen so far (the empty text if none). A
// leading star matches nothing, and a pattern length above MAX_PATTERN is
// taken as MAX_PATTERN. The block accepts one word per clock cycle while the
// result side keeps up. Each word is held in the input register, then the
// whole match row is updated in a single pass of shallow logic into the
// result register. The row loop is the only thing limiting throughput, so
// back-to-back words are taken at full rate while the result side keeps up.
// The pattern registers are at byte addresses 0, 8 and 16 of the 64-bit APB
// port; the pattern bytes are read back as written and the length as its
// low five bits; any write to one of them reloads the match row, so the
// pattern should only be changed between texts while no word is in flight.
module wildcard_star_regex_matcher #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    wsrm_in_if.sink                                i_in,
    wsrm_out_if.source                             o_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [wsrm_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [wsrm_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [wsrm_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import wsrm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Pattern registers.
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_REG_W-1:0]  r_pat_len;

    // Input register.
    logic  r_in_vld;
    t_byte r_in_char;
    logic  r_in_last;
    logic  r_in_empty;

    // Result register.
    logic r_out_vld;
    logic r_out_match;
    logic r_out_done;

    // Match row state. r_fresh means the row is the empty-text row, which is
    // kept ready in r_empty_row, so a reload costs nothing.
    logic [MAX_PATTERN:0] r_row;
    logic [MAX_PATTERN:0] r_empty_row;
    logic                 r_fresh;

    t_pattern             w_pattern;
    t_cfg_idx             w_cfg_idx;
    logic                 w_cfg_wr;
    logic                 w_cfg_hit;
    logic [LEN_W-1:0]     w_len;
    logic [MAX_PATTERN:0] w_cur_row;
    logic [MAX_PATTERN:0] w_step_row;
    logic [MAX_PATTERN:0] w_empty_row;
    logic                 w_advance;
    logic                 n_match;

    assign w_pattern = {r_pat_high, r_pat_low};
    assign w_cfg_idx = t_cfg_idx'(paddr[CFG_ADDR_W-1:3]);
    assign w_cfg_wr  = psel && penable && pwrite;
    // Only a write that lands on one of the three registers reloads the row.
    assign w_cfg_hit = w_cfg_wr &&
                       (w_cfg_idx inside {CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN});
    assign pready    = 1'b1;

    always_comb begin
        case (w_cfg_idx)
            CFG_PAT_LOW:  prdata = r_pat_low;
            CFG_PAT_HIGH: prdata = r_pat_high;
            CFG_PAT_LEN:  prdata = {{(CFG_DATA_W-LEN_REG_W){1'b0}}, r_pat_len};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                CFG_PAT_LOW:  r_pat_low  <= pwdata;
                CFG_PAT_HIGH: r_pat_high <= pwdata;
                CFG_PAT_LEN:  r_pat_len  <= pwdata[LEN_REG_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pattern length in use, clamped to the row size.
    assign w_len = (r_pat_len > LEN_REG_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                         : r_pat_len[LEN_W-1:0];

    assign w_cur_row = r_fresh ? r_empty_row : r_row;

    wsrm_row_logic #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_row_logic (
        .i_pattern   (w_pattern),
        .i_char      (r_in_char),
        .i_row       (w_cur_row),
        .o_step_row  (w_step_row),
        .o_empty_row (w_empty_row)
    );

    // A word moves from the input register to the result register when the
    // result register is empty or its word is being taken this cycle.
    assign w_advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_advance;

    assign n_match = r_in_empty ? w_cur_row[w_len] : w_step_row[w_len];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char  <= i_in.text_char;
            r_in_last  <= i_in.last_char;
            r_in_empty <= i_in.empty_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_match <= n_match;
            r_out_done  <= r_in_empty || r_in_last;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.prefix_matches = r_out_match;
    assign o_out.text_done      = r_out_done;

    // The empty-text row is registered from the pattern registers. A word
    // accepted after a write reaches the row logic in the following cycle at
    // the earliest, by which time this register has caught up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_row <= {{MAX_PATTERN{1'b0}}, 1'b1};
        end else begin
            r_empty_row <= w_empty_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
        end else if (w_cfg_hit) begin
            r_fresh <= 1'b1;
        end else if (w_advance) begin
            r_fresh <= r_in_empty || r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && !r_in_empty) begin
            r_row <= w_step_row;
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the wildcard star matcher: a scoreboard class predicts every
// result word, tasks drive the text stream and APB registers, and a loop drives result ready.
// Depends on wsrm_pkg, wsrm_in_if, wsrm_out_if and the wildcard_star_regex_matcher RTL.

typedef struct packed {
    logic prefix_matches;
    logic text_done;
} t_verdict;

// Holds its own copy of the pattern registers and the match row, and queues the verdict
// expected for every accepted text word until the matching result word turns up.
class verdict_board;
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [4:0]  pat_len;
    logic [16:0] row;
    t_verdict    pending_verdicts[$];
    int          errors;

    function new();
        pat_low  = '0;
        pat_high = '0;
        pat_len  = '0;
        errors   = 0;
        row      = blank_row();
    endfunction

    // Lengths above the pattern store are clipped to its size.
    function int used_len();
        return (pat_len > wsrm_pkg::PAT_BYTES) ? wsrm_pkg::PAT_BYTES : int'(pat_len);
    endfunction

    function wsrm_pkg::t_byte pat_at(int k);
        if (k < 8)
            return pat_low[8*k +: 8];
        return pat_high[8*(k-8) +: 8];
    endfunction

    // Row for the empty text: only the prefixes made of starred items can match.
    function logic [16:0] blank_row();
        logic [16:0] r;
        r = 17'd1;
        for (int j = 2; j <= used_len(); j++) begin
            if (pat_at(j-1) == wsrm_pkg::STAR_CH && r[j-2])
                r[j] = 1'b1;
        end
        return r;
    endfunction

    // One text byte moves the whole row on. A star at the very front has nothing to repeat,
    // so its bit stays clear; a star standing before a star is compared as a plain byte.
    function logic [16:0] advanced_row(wsrm_pkg::t_byte c);
        logic [16:0]     nxt;
        wsrm_pkg::t_byte pc;
        wsrm_pkg::t_byte prev;
        nxt = '0;
        for (int j = 1; j <= used_len(); j++) begin
            pc = pat_at(j-1);
            if (pc == wsrm_pkg::STAR_CH) begin
                if (j >= 2) begin
                    prev   = pat_at(j-2);
                    nxt[j] = nxt[j-2] | (row[j] & (prev == wsrm_pkg::DOT_CH || prev == c));
                end
            end else begin
                nxt[j] = row[j-1] & (pc == wsrm_pkg::DOT_CH || pc == c);
            end
        end
        return nxt;
    endfunction

    function void take_config(logic [1:0] idx, logic [63:0] value);
        case (idx)
            wsrm_pkg::CFG_PAT_LOW:  pat_low  = value;
            wsrm_pkg::CFG_PAT_HIGH: pat_high = value;
            wsrm_pkg::CFG_PAT_LEN:  pat_len  = value[4:0];
            default: return;
        endcase
        row = blank_row();
    endfunction

    function void take_word(wsrm_pkg::t_byte c, logic last, logic empty);
        t_verdict v;
        if (empty) begin
            v.prefix_matches = row[used_len()];
            v.text_done      = 1'b1;
            row              = blank_row();
        end else begin
            row              = advanced_row(c);
            v.prefix_matches = row[used_len()];
            v.text_done      = last;
            if (last)
                row = blank_row();
        end
        pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic got_match, logic got_done);
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result word with nothing expected: prefix_matches=%0b text_done=%0b",
                         got_match, got_done);
            return;
        end
        want = pending_verdicts.pop_front();
        if (got_match !== want.prefix_matches || got_done !== want.text_done) begin
            errors++;
            if (errors <= 10)
                $display("verdict mismatch: expected prefix_matches=%0b text_done=%0b, got %0b %0b",
                         want.prefix_matches, want.text_done, got_match, got_done);
        end
    endfunction
endclass

module testbench;
    import wsrm_pkg::*;

    localparam int         MAX_PAT        = 16;
    localparam int         TOTAL_WORDS    = 625;
    localparam int         PHASE_WORDS    = 45;
    localparam int         LIMIT_TIME     = 2_000_000;
    // An index past the three registers; writes to it must leave everything alone.
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic                  pready;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;

    wsrm_in_if  text_bus();
    wsrm_out_if verdict_bus();

    wildcard_star_regex_matcher #(
        .MAX_PATTERN(MAX_PAT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_bus),
        .o_out   (verdict_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    verdict_board board = new();

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int    src_idle_pct   = 0;
    int    sink_stall_pct = 0;
    int    words_sent     = 0;
    // The pattern as last programmed, kept so that matching texts can be built from it.
    t_byte pat_chars[16];
    int    pat_used;
    t_byte text_bytes[$];

    // Period of four time units, two high and two low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver decides at each falling edge whether it takes a result word in the next
    // cycle, so that stalls land on every phase of the pipeline.
    initial begin
        verdict_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            verdict_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Everything is observed at the rising edge, before the block's own registers move.
    // A word is noted before a result is checked, so the expectation always exists first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready)
                board.take_config(paddr[4:3], pwdata);
            if (text_bus.valid && text_bus.ready)
                board.take_word(text_bus.text_char, text_bus.last_char, text_bus.empty_text);
            if (verdict_bus.valid && verdict_bus.ready)
                board.check_verdict(verdict_bus.prefix_matches, verdict_bus.text_done);
        end
    end

    // Text bytes lean on a small alphabet so that patterns actually match, with the dot,
    // the star and arbitrary bytes mixed in so that every bit of the byte is exercised.
    function automatic t_byte any_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'h61 + 8'($urandom_range(2));
        if (r < 78)
            return DOT_CH;
        if (r < 85)
            return STAR_CH;
        return 8'($urandom_range(255));
    endfunction

    // All driving tasks start and finish at a falling edge.
    task automatic send_word(input t_byte c, input logic last, input logic empty);
        while ($urandom_range(99) < src_idle_pct) begin
            text_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        text_bus.valid      = 1'b1;
        text_bus.text_char  = c;
        text_bus.last_char  = last;
        text_bus.empty_text = empty;
        do @(posedge i_clk); while (!text_bus.ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++)
            send_word(t_byte'(s[k]), k == s.len() - 1, 1'b0);
    endtask

    // Holds the sender back until every expected result word has come out.
    task automatic drain_results();
        text_bus.valid = 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(negedge i_clk);
    endtask

    // Setup cycle, then the access cycle, which completes once pready is seen high.
    // The block is emptied first, so no word is in flight while a register changes.
    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        drain_results();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_pattern(input logic [4:0] len);
        logic [63:0] low_word;
        logic [63:0] high_word;
        for (int k = 0; k < 8; k++) begin
            low_word[8*k +: 8]  = pat_chars[k];
            high_word[8*k +: 8] = pat_chars[k+8];
        end
        pat_used = (len > MAX_PAT) ? MAX_PAT : int'(len);
        apb_write(CFG_PAT_LOW, low_word);
        apb_write(CFG_PAT_HIGH, high_word);
        apb_write(CFG_PAT_LEN, {59'd0, len});
    endtask

    function automatic void set_chars(input string s);
        for (int k = 0; k < 16; k++)
            pat_chars[k] = (k < s.len()) ? t_byte'(s[k]) : 8'h00;
    endfunction

    initial begin
        int    phase;
        int    phase_start;
        int    r;
        int    k;
        int    len_pick;
        bit    paused;
        bit    end_with_empty;

        text_bus.valid      = 1'b0;
        text_bus.text_char  = '0;
        text_bus.last_char  = 1'b0;
        text_bus.empty_text = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        i_rst_n             = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. With the reset pattern of length zero only the empty text matches.
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        // An empty word in the middle of a text ends it with the answer so far.
        send_word(8'hFF, 1'b1, 1'b1);

        // A star at the very front has nothing to repeat and matches nothing.
        set_chars("*a");
        program_pattern(5'd2);
        send_string("a");
        send_word(8'h5A, 1'b0, 1'b1);

        set_chars("a*b.c*");
        program_pattern(5'd6);
        send_string("aab.");

        // A length past the end of the store is clipped to the full sixteen bytes.
        // The text is left open so that the write below lands in the middle of it.
        set_chars("a.*b*c*d*e*f*g*.");
        program_pattern(5'd31);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h7A, 1'b0, 1'b0);

        // A write past the last register must leave pattern and row untouched.
        apb_write(CFG_UNUSED_IDX, {$urandom, $urandom});
        send_word(8'h61, 1'b0, 1'b1);

        // Two stars in a row: the second repeats a literal star byte.
        set_chars("a**");
        program_pattern(5'd3);
        send_string("a**");

        // All-ones registers: pattern byte 0xFF against the top and next-to-top byte values.
        for (int j = 0; j < 16; j++)
            pat_chars[j] = 8'hFF;
        program_pattern(5'd1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFE, 1'b1, 1'b0);

        // Random part: phases rotate through the idling modes, and each starts from a fresh
        // pattern written while nothing is in flight.
        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            drain_results();
            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 82;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 82;
                end
                default: begin
                    src_idle_pct   = 30;
                    sink_stall_pct = 30;
                end
            endcase

            for (int j = 0; j < 16; j++) begin
                r = $urandom_range(99);
                if (r < 50)
                    pat_chars[j] = 8'h61 + 8'($urandom_range(2));
                else if (r < 65)
                    pat_chars[j] = DOT_CH;
                else if (r < 90)
                    pat_chars[j] = STAR_CH;
                else
                    pat_chars[j] = 8'($urandom_range(255));
            end
            if (phase == 1)
                len_pick = 16;
            else if (phase == 2)
                len_pick = 0;
            else if ($urandom_range(99) < 12)
                len_pick = 17 + $urandom_range(14);
            else
                len_pick = $urandom_range(16);
            program_pattern(5'(len_pick));

            phase_start = words_sent;
            paused      = 1'b0;
            while (words_sent - phase_start < PHASE_WORDS) begin
                // Once per phase the sender waits for the block to empty completely.
                if (!paused && words_sent - phase_start >= 20) begin
                    drain_results();
                    paused = 1'b1;
                end

                // Most texts are built to match the pattern, some are then spoilt in one
                // byte, and the rest are short random noise.
                text_bytes.delete();
                r = $urandom_range(99);
                if (r < 75) begin
                    k = 0;
                    while (k < pat_used) begin
                        if (k + 1 < pat_used && pat_chars[k+1] == STAR_CH) begin
                            repeat ($urandom_range(3))
                                text_bytes.push_back((pat_chars[k] == DOT_CH) ?
                                                     any_text_byte() : pat_chars[k]);
                            k += 2;
                        end else if (pat_chars[k] == STAR_CH) begin
                            k++;
                        end else begin
                            text_bytes.push_back((pat_chars[k] == DOT_CH) ?
                                                 any_text_byte() : pat_chars[k]);
                            k++;
                        end
                    end
                    if (r >= 60) begin
                        if (text_bytes.size() == 0)
                            text_bytes.push_back(any_text_byte());
                        else
                            text_bytes[$urandom_range(text_bytes.size() - 1)] = any_text_byte();
                    end
                end else begin
                    repeat ($urandom_range(8))
                        text_bytes.push_back(any_text_byte());
                end

                end_with_empty = (text_bytes.size() == 0) || ($urandom_range(9) == 0);
                for (int j = 0; j < text_bytes.size(); j++)
                    send_word(text_bytes[j], !end_with_empty && j == text_bytes.size() - 1,
                              1'b0);
                if (end_with_empty)
                    send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end
            phase++;
        end

        // Let the last result words out, then wait for anything stray.
        drain_results();
        repeat (8) @(negedge i_clk);
        if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog: a correct run finishes far inside this time.
    initial begin
        #(LIMIT_TIME);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

[files.f]
design/wsrm_pkg.sv
design/wsrm_ifs.sv
design/wsrm_row_logic.sv
design/wildcard_star_regex_matcher.sv
tb/testbench.sv
